@@ hdl/shn_pkg.sv @@
// shared types, constants and round functions for the siphash node generator
package shn_pkg;

    localparam int unsigned WORD_W  = 64;
    localparam int unsigned NONCE_W = 32;
    localparam int unsigned NODE_W  = 32;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned NUM_ROUNDS = 6;
    localparam int unsigned MIX_AFTER  = 2;

    localparam logic [NODE_W-1:0] MASK_RESET = 32'h1FFF_FFFF;
    localparam logic [WORD_W-1:0] FINAL_XOR  = 64'h0000_0000_0000_00FF;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KEY0 = 3'd0,
        CFG_KEY1 = 3'd1,
        CFG_KEY2 = 3'd2,
        CFG_KEY3 = 3'd3,
        CFG_MASK = 3'd4
    } t_cfg_index;

    // hash state plus what travels alongside it
    typedef struct packed {
        logic [WORD_W-1:0]  a;
        logic [WORD_W-1:0]  b;
        logic [WORD_W-1:0]  c;
        logic [WORD_W-1:0]  d;
        logic [NONCE_W-1:0] w;
        logic               side;
    } t_sip_state;

    function automatic logic [WORD_W-1:0] rotl64(input logic [WORD_W-1:0] x,
                                                 input int unsigned sh);
        rotl64 = (x << sh) | (x >> (WORD_W - sh));
    endfunction

    // first half of a sipround
    function automatic t_sip_state half_round_lo(input t_sip_state s);
        t_sip_state r;
        r   = s;
        r.a = s.a + s.b;
        r.c = s.c + s.d;
        r.b = rotl64(s.b, 13) ^ r.a;
        r.d = rotl64(s.d, 16) ^ r.c;
        r.a = rotl64(r.a, 32);
        return r;
    endfunction

    // second half of a sipround
    function automatic t_sip_state half_round_hi(input t_sip_state s);
        t_sip_state r;
        r   = s;
        r.c = s.c + s.b;
        r.a = s.a + s.d;
        r.b = rotl64(s.b, 17) ^ r.c;
        r.d = rotl64(s.d, 21) ^ r.a;
        r.c = rotl64(r.c, 32);
        return r;
    endfunction

endpackage

@@ hdl/shn_round.sv @@
// one sipround split over two pipeline stages with per-stage flow control
module shn_round (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  shn_pkg::t_sip_state i_state,
    output logic                o_valid,
    input  logic                i_stall,
    output shn_pkg::t_sip_state o_state
);
    import shn_pkg::*;

    logic       r_a_valid, r_b_valid;
    t_sip_state r_a_state, r_b_state;
    logic       a_ready, b_ready;

    // a stage moves when it is empty or its successor takes its transaction
    assign b_ready = !r_b_valid || !i_stall;
    assign a_ready = !r_a_valid || b_ready;
    assign o_stall = !a_ready;

    // first half round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_valid;
        end
        if (a_ready && i_valid) begin
            r_a_state <= half_round_lo(i_state);
        end
    end

    // second half round
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (b_ready) begin
            r_b_valid <= r_a_valid;
        end
        if (b_ready && r_a_valid) begin
            r_b_state <= half_round_hi(r_a_state);
        end
    end

    assign o_valid = r_b_valid;
    assign o_state = r_b_state;

`ifndef SYNTH
    // back pressure only when both stages hold work
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_a_valid && r_b_valid))
        else $error("round stalls upstream with an empty stage");

    // a held result keeps its data
    a_hold_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && i_stall) |=> (r_b_valid && $stable(r_b_state)))
        else $error("stalled round output changed");

    // a transaction in the first stage is never dropped on a stall
    a_keep_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && !b_ready) |=> (r_a_valid && $stable(r_a_state)))
        else $error("first half-round stage lost its transaction");
`endif

endmodule

@@ hdl/siphash_node_generator.sv @@
// siphash-2-4 graph node generator top level
// Takes one (edge_nonce, side) transaction per cycle and returns one
// (hash_value, node_index) transaction for each, in order. From acceptance to a valid result
// a transaction passes these stages: one stage loads the key state, each of
// the six siprounds takes two stages (one 64-bit add level per stage), and
// one stage forms the final hash and masked node index. Sustained throughput
// is one transaction per cycle while the output is not stalled; each stage holds on its own when the output
// is stalled, so bubbles close up. Key words and node mask are read live
// and must only be written while no transaction is in flight.
module siphash_node_generator (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // configuration write port
    input  logic                                   i_cfg_wr_en,
    input  logic [shn_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [shn_pkg::WORD_W-1:0]             i_cfg_wr_data,
    // input channel
    input  logic                                   i_valid,
    output logic                                   o_stall,
    input  logic [shn_pkg::NONCE_W-1:0]            i_edge_nonce,
    input  logic                                   i_side,
    // output channel
    output logic                                   o_valid,
    input  logic                                   i_stall,
    output logic [shn_pkg::WORD_W-1:0]             o_hash_value,
    output logic [shn_pkg::NODE_W-1:0]             o_node_index
);
    import shn_pkg::*;

    logic [WORD_W-1:0] r_key0, r_key1, r_key2, r_key3;
    logic [NODE_W-1:0] r_mask;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key0 <= '0;
            r_key1 <= '0;
            r_key2 <= '0;
            r_key3 <= '0;
            r_mask <= MASK_RESET;
        end else if (i_cfg_wr_en) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_KEY0: r_key0 <= i_cfg_wr_data;
                CFG_KEY1: r_key1 <= i_cfg_wr_data;
                CFG_KEY2: r_key2 <= i_cfg_wr_data;
                CFG_KEY3: r_key3 <= i_cfg_wr_data;
                CFG_MASK: r_mask <= i_cfg_wr_data[NODE_W-1:0];
                default: ;
            endcase
        end
    end

    // pipeline links between stages
    logic       link_valid [NUM_ROUNDS+1];
    logic       link_stall [NUM_ROUNDS+1];
    t_sip_state link_state [NUM_ROUNDS+1];
    t_sip_state round_in   [NUM_ROUNDS];

    logic       r_in_valid;
    t_sip_state r_in_state;
    t_sip_state n_in_state;
    logic       in_ready;

    // input stage: form the hashed word and load the key state
    always_comb begin
        n_in_state.w    = {i_edge_nonce[NONCE_W-2:0], i_side};
        n_in_state.side = i_side;
        n_in_state.a    = r_key0;
        n_in_state.b    = r_key1;
        n_in_state.c    = r_key2;
        n_in_state.d    = r_key3 ^ {{(WORD_W-NONCE_W){1'b0}}, n_in_state.w};
    end

    assign in_ready = !r_in_valid || !link_stall[0];
    assign o_stall  = !in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_ready) begin
            r_in_valid <= i_valid;
        end
        if (in_ready && i_valid) begin
            r_in_state <= n_in_state;
        end
    end

    assign link_valid[0] = r_in_valid;
    assign link_state[0] = r_in_state;

    // six siprounds; the message word and finalization constant enter after round two
    for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
        if (g == MIX_AFTER) begin : g_mix
            always_comb begin
                round_in[g]   = link_state[g];
                round_in[g].a = link_state[g].a
                              ^ {{(WORD_W-NONCE_W){1'b0}}, link_state[g].w};
                round_in[g].c = link_state[g].c ^ FINAL_XOR;
            end
        end else begin : g_pass
            assign round_in[g] = link_state[g];
        end

        shn_round u_round (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (link_valid[g]),
            .o_stall (link_stall[g]),
            .i_state (round_in[g]),
            .o_valid (link_valid[g+1]),
            .i_stall (link_stall[g+1]),
            .o_state (link_state[g+1])
        );
    end

    // output stage: fold the state and build the node index
    logic              r_out_valid;
    logic [WORD_W-1:0] r_hash;
    logic [NODE_W-1:0] r_node;
    logic [WORD_W-1:0] n_hash;
    logic [NODE_W-1:0] n_node;
    logic              out_ready;
    t_sip_state        fin;

    assign fin       = link_state[NUM_ROUNDS];
    assign n_hash    = (fin.a ^ fin.b) ^ (fin.c ^ fin.d);
    assign n_node    = {n_hash[NODE_W-2:0] & r_mask[NODE_W-2:0], fin.side};
    assign out_ready = !r_out_valid || !i_stall;
    assign link_stall[NUM_ROUNDS] = !out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= link_valid[NUM_ROUNDS];
        end
        if (out_ready && link_valid[NUM_ROUNDS]) begin
            r_hash <= n_hash;
            r_node <= n_node;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_hash_value = r_hash;
    assign o_node_index = r_node;

`ifndef SYNTH
    // an accepted transaction always lands in the input stage
    a_in_capture: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> r_in_valid)
        else $error("accepted transaction missing from input stage");

    // upstream is held only while the input stage is occupied
    a_stall_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> r_in_valid)
        else $error("input stalled with an empty input stage");

    // the node index low bit follows the side bit of the same transaction
    a_side_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_ready && link_valid[NUM_ROUNDS]) |=> (r_node[0] == $past(fin.side)))
        else $error("node index side bit does not match transaction");
`endif

endmodule

@@ tb/tb_siphash_node_generator.sv @@
// self-checking testbench for the siphash-2-4 graph node generator
module tb_siphash_node_generator;
    timeunit 1ns;
    timeprecision 1ps;

    import shn_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 100000;
    localparam int unsigned HOLD_AT     = 600;
    localparam int unsigned HOLD_LEN    = 80;
    localparam int unsigned QUIET_FROM  = 900;
    localparam int unsigned QUIET_TO    = 1700;
    localparam int unsigned DRAIN_WAIT  = 20;

    typedef struct {
        logic [NONCE_W-1:0] nonce;
        logic               side;
    } t_edge_req;

    typedef struct {
        logic [WORD_W-1:0] hash;
        logic [NODE_W-1:0] node;
    } t_node_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_wr_data = '0;
    logic                 drv_valid = 1'b0;
    logic [NONCE_W-1:0]   drv_nonce = '0;
    logic                 drv_side = 1'b0;
    logic                 rx_stall = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [WORD_W-1:0]    o_hash_value;
    logic [NODE_W-1:0]    o_node_index;

    // shadow of the configuration registers
    logic [WORD_W-1:0]    key_v0 = '0;
    logic [WORD_W-1:0]    key_v1 = '0;
    logic [WORD_W-1:0]    key_v2 = '0;
    logic [WORD_W-1:0]    key_v3 = '0;
    logic [NODE_W-1:0]    node_mask = MASK_RESET;

    t_edge_req            edge_req_q[$];
    t_node_result         node_expect_q[$];
    logic                 in_taken = 1'b0;
    int unsigned          accepted_cnt = 0;
    int unsigned          cycle_cnt = 0;
    int unsigned          fail_cnt = 0;
    int unsigned          hold_left = 0;
    logic                 hold_armed = 1'b1;
    logic                 idle_ok;

    siphash_node_generator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (cfg_wr_en),
        .i_cfg_index   (cfg_index),
        .i_cfg_wr_data (cfg_wr_data),
        .i_valid       (drv_valid),
        .o_stall       (o_stall),
        .i_edge_nonce  (drv_nonce),
        .i_side        (drv_side),
        .o_valid       (o_valid),
        .i_stall       (rx_stall),
        .o_hash_value  (o_hash_value),
        .o_node_index  (o_node_index)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // random idling is switched off for one stretch of the run
    assign idle_ok = !(cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO);

    function automatic logic [WORD_W-1:0] rot_left(input logic [WORD_W-1:0] x,
                                                   input int unsigned n);
        return (x << n) | (x >> (WORD_W - n));
    endfunction

    // siphash-2-4 of the edge word and the masked node index
    function automatic t_node_result predict_node(input logic [NONCE_W-1:0] nonce,
                                                  input logic side);
        logic [NONCE_W-1:0] word;
        logic [WORD_W-1:0]  m;
        logic [WORD_W-1:0]  v0, v1, v2, v3;
        t_node_result       r;
        word = {nonce[NONCE_W-2:0], side};
        m    = {{(WORD_W-NONCE_W){1'b0}}, word};
        v0   = key_v0;
        v1   = key_v1;
        v2   = key_v2;
        v3   = key_v3 ^ m;
        for (int k = 0; k < NUM_ROUNDS; k++) begin
            if (k == MIX_AFTER) begin
                v0 = v0 ^ m;
                v2 = v2 ^ FINAL_XOR;
            end
            v0 = v0 + v1;
            v2 = v2 + v3;
            v1 = rot_left(v1, 13) ^ v0;
            v3 = rot_left(v3, 16) ^ v2;
            v0 = rot_left(v0, 32);
            v2 = v2 + v1;
            v0 = v0 + v3;
            v1 = rot_left(v1, 17) ^ v2;
            v3 = rot_left(v3, 21) ^ v0;
            v2 = rot_left(v2, 32);
        end
        r.hash = v0 ^ v1 ^ v2 ^ v3;
        r.node = {r.hash[NODE_W-2:0] & node_mask[NODE_W-2:0], side};
        return r;
    endfunction

    // random edge, biased toward the wrap and sign boundaries
    function automatic t_edge_req rand_edge();
        t_edge_req e;
        case ($urandom_range(7))
            0: e.nonce = 32'hFFFF_FFFF - $urandom_range(3);
            1: e.nonce = $urandom_range(3);
            2: e.nonce = 32'h8000_0000 ^ $urandom_range(1);
            default: e.nonce = $urandom;
        endcase
        e.side = 1'($urandom_range(1));
        return e;
    endfunction

    // input accept, expectation at the moment of the transaction
    always @(posedge i_clk) begin
        in_taken <= drv_valid && !o_stall && i_rst_n;
        if (i_rst_n && drv_valid && !o_stall) begin
            node_expect_q.push_back(predict_node(drv_nonce, drv_side));
            accepted_cnt <= accepted_cnt + 1;
        end
    end

    // input driver
    always @(negedge i_clk) begin
        t_edge_req e;
        if (!i_rst_n) begin
            drv_valid <= 1'b0;
        end else if (!drv_valid || in_taken) begin
            if (edge_req_q.size() != 0 && !(idle_ok && $urandom_range(99) < 9)) begin
                e = edge_req_q.pop_front();
                drv_valid <= 1'b1;
                drv_nonce <= e.nonce;
                drv_side  <= e.side;
            end else begin
                drv_valid <= 1'b0;
            end
        end
    end

    // output stall: random, plus one long hold-off to back up the pipeline
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rx_stall <= 1'b0;
        end else if (hold_left != 0) begin
            rx_stall  <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_armed && accepted_cnt >= HOLD_AT) begin
            hold_armed <= 1'b0;
            hold_left  <= HOLD_LEN;
            rx_stall   <= 1'b1;
        end else begin
            rx_stall <= idle_ok && ($urandom_range(99) < 9);
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_node_result x;
        int unsigned  errs;
        errs = 0;
        if (i_rst_n && o_valid && !rx_stall) begin
            if (node_expect_q.size() == 0) begin
                $error("unexpected result: hash_value %h node_index %h",
                       o_hash_value, o_node_index);
                errs = errs + 1;
            end else begin
                x = node_expect_q.pop_front();
                if (o_hash_value !== x.hash) begin
                    $error("hash_value: expected %h, actual %h", x.hash, o_hash_value);
                    errs = errs + 1;
                end
                if (o_node_index !== x.node) begin
                    $error("node_index: expected %h, actual %h", x.node, o_node_index);
                    errs = errs + 1;
                end
            end
        end
        if (errs != 0) begin
            fail_cnt <= fail_cnt + errs;
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("tb_siphash_node_generator: FAIL");
            $finish;
        end
    end

    // register write, shadow updated alongside
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
        @(negedge i_clk);
        cfg_wr_en   = 1'b1;
        cfg_index   = idx;
        cfg_wr_data = data;
        case (idx)
            CFG_KEY0: key_v0 = data;
            CFG_KEY1: key_v1 = data;
            CFG_KEY2: key_v2 = data;
            CFG_KEY3: key_v3 = data;
            CFG_MASK: node_mask = data[NODE_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        cfg_wr_en = 1'b0;
    endtask

    task automatic load_config(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                               input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                               input logic [WORD_W-1:0] mask_data);
        write_reg(CFG_KEY0, k0);
        write_reg(CFG_KEY1, k1);
        write_reg(CFG_KEY2, k2);
        write_reg(CFG_KEY3, k3);
        write_reg(CFG_MASK, mask_data);
    endtask

    // writes to indexes past the mask register must change nothing
    task automatic poke_unused();
        for (int k = 1; k <= 3; k++)
            write_reg(CFG_IDX_W'(CFG_MASK + k), {$urandom, $urandom});
    endtask

    // sender pause: nothing queued, nothing offered, nothing outstanding
    task automatic wait_drained();
        do @(posedge i_clk);
        while (edge_req_q.size() != 0 || drv_valid || node_expect_q.size() != 0);
    endtask

    task automatic push_directed();
        t_edge_req e;
        logic [NONCE_W-1:0] nonces [10];
        nonces = '{32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                   32'h7FFF_FFFF, 32'h8000_0000, 32'hAAAA_AAAA, 32'h5555_5555,
                   32'h0000_0001, 32'h4000_0000};
        for (int k = 0; k < 10; k++) begin
            e.nonce = nonces[k];
            e.side  = (k == 1 || k == 3 || k == 4 || k == 6 || k == 9);
            edge_req_q.push_back(e);
        end
    endtask

    task automatic push_random(input int unsigned n);
        repeat (n) edge_req_q.push_back(rand_edge());
    endtask

    // stimulus sequence
    initial begin
        repeat (9) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset configuration: zero keys, default mask
        push_directed();
        wait_drained();

        // all-ones keys, all-ones mask with stray upper bits
        load_config('1, '1, '1, '1, '1);
        push_directed();
        push_random(100);
        wait_drained();

        // all-zero keys, zero mask
        load_config('0, '0, '0, '0, '0);
        push_random(100);
        wait_drained();

        // long random run, hold-off lands in here
        poke_unused();
        load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                    {$urandom, $urandom}, {$urandom, 32'(MASK_RESET)});
        push_random(1000);
        wait_drained();

        // short bursts, fresh keys and mask between each
        repeat (8) begin
            poke_unused();
            load_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                        {$urandom, $urandom}, {$urandom, $urandom});
            push_random(50);
            wait_drained();
        end

        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (fail_cnt == 0 && node_expect_q.size() == 0) begin
            $display("tb_siphash_node_generator: PASS");
        end else begin
            $display("tb_siphash_node_generator: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
hdl/shn_pkg.sv
hdl/shn_round.sv
hdl/siphash_node_generator.sv
tb/tb_siphash_node_generator.sv
